### rtl/ph_two_point_calibrated_meter_defines.svh
// assertion macros for the two-point calibrated ph meter
// used by the top level; expects clk and rst_n in scope

`ifndef PH_TWO_POINT_CALIBRATED_METER_DEFINES_SVH
`define PH_TWO_POINT_CALIBRATED_METER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PHCAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PHCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/phcal_pkg.sv
// shared types and constants of the two-point calibrated ph meter
// no dependencies; used by the interfaces and every module

package phcal_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CENTI_W  = 11;
    localparam int STATUS_W = 3;
    localparam int PROG_W   = 7;
    localparam int SUM_W    = 19;
    localparam int CNT_W    = 7;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [CENTI_W-1:0]  CENTI_MAX  = 11'd1400;
    // 2 * 700 + 1 and 2 * 300, doubled for round-half-up
    localparam logic [10:0] SPAN_GAIN  = 11'd1401;
    localparam logic [9:0]  SLOPE_GAIN = 10'd600;

    localparam logic [PROG_W-1:0] PROG_NONE    = 7'd0;
    localparam logic [PROG_W-1:0] PROG_ENTER   = 7'd35;
    localparam logic [PROG_W-1:0] PROG_CAPTURE = 7'd70;
    localparam logic [PROG_W-1:0] PROG_DONE    = 7'd100;

    typedef enum logic [1:0] {
        CMD_MEASURE = 2'd0,
        CMD_ENTER   = 2'd1,
        CMD_CAPTURE = 2'd2,
        CMD_EXIT    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        CAL_NONE    = 3'd0,
        CAL_ENTERED = 3'd1,
        CAL_GOT7    = 3'd2,
        CAL_GOT4    = 3'd3,
        CAL_RETRY   = 3'd4,
        CAL_SUCCESS = 3'd5,
        CAL_FAILED  = 3'd6
    } cal_status_t;

    typedef enum logic [2:0] {
        REG_W7_LOW  = 3'd0,
        REG_W7_HIGH = 3'd1,
        REG_W4_LOW  = 3'd2,
        REG_W4_HIGH = 3'd3,
        REG_N_DEF   = 3'd4,
        REG_A_DEF   = 3'd5
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WAIT = 1'b1
    } top_state_t;

    typedef enum logic [2:0] {
        CV_IDLE  = 3'd0,
        CV_PREP  = 3'd1,
        CV_SUB   = 3'd2,
        CV_MUL   = 3'd3,
        CV_ADD   = 3'd4,
        CV_CHECK = 3'd5,
        CV_DIV   = 3'd6,
        CV_DONE  = 3'd7
    } conv_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] window7_low;
        logic [SAMPLE_W-1:0] window7_high;
        logic [SAMPLE_W-1:0] window4_low;
        logic [SAMPLE_W-1:0] window4_high;
        logic [SAMPLE_W-1:0] neutral_default;
        logic [SAMPLE_W-1:0] acid_default;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        window7_low:     12'd1800,
        window7_high:    12'd2300,
        window4_low:     12'd2500,
        window4_high:    12'd3100,
        neutral_default: 12'd2048,
        acid_default:    12'd2800
    };

    typedef struct packed {
        logic                start;
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] neutral;
        logic [SAMPLE_W-1:0] acid;
    } conv_req_t;

    typedef struct packed {
        logic               done;
        logic [CENTI_W-1:0] centi;
        logic               derr;
    } conv_rsp_t;

    typedef struct packed {
        logic               ph_valid;
        logic [CENTI_W-1:0] ph_centi;
        logic               divide_error;
        cal_status_t        cal_status;
        logic [PROG_W-1:0]  progress;
    } result_t;

endpackage

### rtl/phcal_in_if.sv
// input channel of the ph meter: command and raw sample
// depends on phcal_pkg

interface phcal_in_if;
    logic                           valid;
    logic                           ready;
    phcal_pkg::cmd_t                command;
    logic [phcal_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink (input valid, input command, input sample, output ready);
endinterface

### rtl/phcal_out_if.sv
// result channel of the ph meter
// depends on phcal_pkg

interface phcal_out_if;
    logic                           valid;
    logic                           ready;
    logic                           ph_valid;
    logic [phcal_pkg::CENTI_W-1:0]  ph_centi;
    logic                           divide_error;
    logic [phcal_pkg::STATUS_W-1:0] cal_status;
    logic [phcal_pkg::PROG_W-1:0]   progress;

    modport source (
        output valid, output ph_valid, output ph_centi, output divide_error,
        output cal_status, output progress, input ready
    );
    modport sink (
        input valid, input ph_valid, input ph_centi, input divide_error,
        input cal_status, input progress, output ready
    );
endinterface

### rtl/phcal_regs.sv
// apb configuration registers: buffer windows and default points
// depends on phcal_pkg

module phcal_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [phcal_pkg::ADDR_W-1:0] paddr,
    input  logic [phcal_pkg::DATA_W-1:0] pwdata,
    output logic [phcal_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output phcal_pkg::cfg_t              cfg
);

    phcal_pkg::cfg_t                 cfg_reg;
    phcal_pkg::cfg_t                 cfg_next;
    logic [2:0]                      idx;
    logic                            wr_en;
    logic [phcal_pkg::SAMPLE_W-1:0]  wval;
    logic [phcal_pkg::SAMPLE_W-1:0]  rval;

    assign idx    = paddr[phcal_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign wval   = pwdata[phcal_pkg::SAMPLE_W-1:0];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign prdata = {{(phcal_pkg::DATA_W-phcal_pkg::SAMPLE_W){1'b0}}, rval};

    always_comb
    begin
        cfg_next = cfg_reg;
        rval     = '0;
        unique case (idx)
            phcal_pkg::REG_W7_LOW:
            begin
                rval = cfg_reg.window7_low;
                if (wr_en) cfg_next.window7_low = wval;
            end
            phcal_pkg::REG_W7_HIGH:
            begin
                rval = cfg_reg.window7_high;
                if (wr_en) cfg_next.window7_high = wval;
            end
            phcal_pkg::REG_W4_LOW:
            begin
                rval = cfg_reg.window4_low;
                if (wr_en) cfg_next.window4_low = wval;
            end
            phcal_pkg::REG_W4_HIGH:
            begin
                rval = cfg_reg.window4_high;
                if (wr_en) cfg_next.window4_high = wval;
            end
            phcal_pkg::REG_N_DEF:
            begin
                rval = cfg_reg.neutral_default;
                if (wr_en) cfg_next.neutral_default = wval;
            end
            phcal_pkg::REG_A_DEF:
            begin
                rval = cfg_reg.acid_default;
                if (wr_en) cfg_next.acid_default = wval;
            end
            default:
            begin
                rval = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= phcal_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/phcal_conv.sv
// burst sum to ph conversion: setup steps then a bit-serial restoring divider
// depends on phcal_pkg

module phcal_conv
#(
    parameter int BURST_SAMPLES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  phcal_pkg::conv_req_t req,
    output phcal_pkg::conv_rsp_t rsp
);

    localparam int SW     = phcal_pkg::SAMPLE_W;
    localparam int QW     = phcal_pkg::CENTI_W;
    localparam int B_W    = $clog2(BURST_SAMPLES + 1);
    localparam int NB_W   = SW + B_W;
    localparam int T_W    = NB_W + 1;
    localparam int P1_W   = NB_W + 11;
    localparam int P2_W   = T_W + 10;
    localparam int N_W    = P2_W + 2;
    localparam int D_W    = NB_W + 1;
    localparam int DS_W   = D_W + QW;
    localparam int QCNT_W = $clog2(QW);
    localparam logic [B_W-1:0]    B_VAL    = B_W'(BURST_SAMPLES);
    localparam logic [NB_W-1:0]   FULL_SUM = NB_W'(4095 * BURST_SAMPLES);
    localparam logic [QCNT_W-1:0] Q_LAST   = QCNT_W'(QW - 1);

    phcal_pkg::conv_state_t state_reg, state_next;
    logic [NB_W-1:0]        sum_reg, sum_next;
    logic [SW-1:0]          n_reg, n_next;
    logic [SW-1:0]          a_reg, a_next;
    logic [NB_W-1:0]        nb_reg, nb_next;
    logic [SW-1:0]          p_reg, p_next;
    logic                   neg_reg, neg_next;
    logic signed [T_W-1:0]  tt_reg, tt_next;
    logic [NB_W-1:0]        bp_reg, bp_next;
    logic [P1_W-1:0]        p1_reg, p1_next;
    logic signed [P2_W-1:0] p2_reg, p2_next;
    logic signed [N_W-1:0]  num_reg, num_next;
    logic [D_W-1:0]         d_reg, d_next;
    logic [DS_W-1:0]        rem_reg, rem_next;
    logic [DS_W-1:0]        dsh_reg, dsh_next;
    logic [QW-1:0]          q_reg, q_next;
    logic [QCNT_W-1:0]      cnt_reg, cnt_next;
    logic [QW-1:0]          centi_reg, centi_next;
    logic                   derr_reg, derr_next;
    logic                   ge;
    logic [QW-1:0]          q_shift;

    assign rsp.done  = (state_reg == phcal_pkg::CV_DONE);
    assign rsp.centi = centi_reg;
    assign rsp.derr  = derr_reg;

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        a_next     = a_reg;
        nb_next    = nb_reg;
        p_next     = p_reg;
        neg_next   = neg_reg;
        tt_next    = tt_reg;
        bp_next    = bp_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        num_next   = num_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        centi_next = centi_reg;
        derr_next  = derr_reg;
        ge         = (rem_reg >= dsh_reg);
        q_shift    = {q_reg[QW-2:0], ge};

        unique case (state_reg)
            phcal_pkg::CV_IDLE:
            begin
                if (req.start)
                begin
                    sum_next   = NB_W'(req.sum);
                    n_next     = req.neutral;
                    a_next     = req.acid;
                    state_next = phcal_pkg::CV_PREP;
                end
            end
            phcal_pkg::CV_PREP:
            begin
                nb_next = {{B_W{1'b0}}, n_reg} * {{SW{1'b0}}, B_VAL};
                if (n_reg > a_reg)
                begin
                    p_next   = n_reg - a_reg;
                    neg_next = 1'b0;
                end
                else
                begin
                    p_next   = a_reg - n_reg;
                    neg_next = 1'b1;
                end
                centi_next = '0;
                derr_next  = 1'b0;
                if (sum_reg == FULL_SUM)
                begin
                    state_next = phcal_pkg::CV_DONE;
                end
                else if (n_reg == a_reg)
                begin
                    derr_next  = 1'b1;
                    state_next = phcal_pkg::CV_DONE;
                end
                else
                begin
                    state_next = phcal_pkg::CV_SUB;
                end
            end
            phcal_pkg::CV_SUB:
            begin
                // offset from the neutral point, sign folded into the slope
                if (neg_reg)
                    tt_next = $signed({1'b0, nb_reg}) - $signed({1'b0, sum_reg});
                else
                    tt_next = $signed({1'b0, sum_reg}) - $signed({1'b0, nb_reg});
                bp_next    = {{B_W{1'b0}}, p_reg} * {{SW{1'b0}}, B_VAL};
                state_next = phcal_pkg::CV_MUL;
            end
            phcal_pkg::CV_MUL:
            begin
                p1_next    = {{(P1_W-NB_W){1'b0}}, bp_reg}
                             * {{(P1_W-11){1'b0}}, phcal_pkg::SPAN_GAIN};
                p2_next    = $signed({{(P2_W-T_W){tt_reg[T_W-1]}}, tt_reg})
                             * $signed({{(P2_W-10){1'b0}}, phcal_pkg::SLOPE_GAIN});
                state_next = phcal_pkg::CV_ADD;
            end
            phcal_pkg::CV_ADD:
            begin
                num_next   = $signed({{(N_W-P1_W){1'b0}}, p1_reg})
                             + $signed({{(N_W-P2_W){p2_reg[P2_W-1]}}, p2_reg});
                d_next     = {bp_reg, 1'b0};
                state_next = phcal_pkg::CV_CHECK;
            end
            phcal_pkg::CV_CHECK:
            begin
                derr_next = 1'b0;
                if (num_reg < $signed({{(N_W-D_W){1'b0}}, d_reg}))
                begin
                    centi_next = '0;
                    state_next = phcal_pkg::CV_DONE;
                end
                else if (num_reg[N_W-2:0] >= {d_reg, {QW{1'b0}}})
                begin
                    centi_next = phcal_pkg::CENTI_MAX;
                    state_next = phcal_pkg::CV_DONE;
                end
                else
                begin
                    rem_next   = num_reg[N_W-2:0];
                    dsh_next   = {1'b0, d_reg, {(QW-1){1'b0}}};
                    q_next     = '0;
                    cnt_next   = Q_LAST;
                    state_next = phcal_pkg::CV_DIV;
                end
            end
            phcal_pkg::CV_DIV:
            begin
                if (ge) rem_next = rem_reg - dsh_reg;
                q_next   = q_shift;
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    centi_next = (q_shift > phcal_pkg::CENTI_MAX) ? phcal_pkg::CENTI_MAX
                                                                  : q_shift;
                    state_next = phcal_pkg::CV_DONE;
                end
            end
            phcal_pkg::CV_DONE:
            begin
                state_next = phcal_pkg::CV_IDLE;
            end
            default:
            begin
                state_next = phcal_pkg::CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phcal_pkg::CV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        n_reg     <= n_next;
        a_reg     <= a_next;
        nb_reg    <= nb_next;
        p_reg     <= p_next;
        neg_reg   <= neg_next;
        tt_reg    <= tt_next;
        bp_reg    <= bp_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        num_reg   <= num_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        centi_reg <= centi_next;
        derr_reg  <= derr_next;
    end

endmodule

### rtl/ph_two_point_calibrated_meter.sv
// top level of the two-point calibrated ph meter: commands, burst sum, result stage
// depends on phcal_pkg, phcal_in_if, phcal_out_if, phcal_regs, phcal_conv and the defines
//
//   port      dir   handshake          beat contents
//   in_ch     in    valid / ready      command, sample
//   out_ch    out   valid / ready      ph_valid, ph_centi, divide_error, cal_status, progress
//   apb       in    psel / penable     paddr, pwdata, prdata (pready tied high)
//
// commands and mid-burst readings are taken one beat per cycle while the output register is not stalled
// a reading that closes a burst holds off the next input beat through 5 setup steps,
//   the 11-step divider, a done step and a reload step; the divider is skipped when the result is
//   zero or saturates, and all but the first setup step when the sum is full scale or the points are equal
// rst_n clears control flags and loads the register defaults
// a result beat waits in a holding register while the output register is stalled

`include "ph_two_point_calibrated_meter_defines.svh"

module ph_two_point_calibrated_meter
#(
    parameter int BURST_SAMPLES = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    phcal_in_if.sink                     in_ch,
    phcal_out_if.source                  out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [phcal_pkg::ADDR_W-1:0] paddr,
    input  logic [phcal_pkg::DATA_W-1:0] pwdata,
    output logic [phcal_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int SW   = phcal_pkg::SAMPLE_W;
    localparam int CW   = phcal_pkg::CNT_W;
    localparam logic [CW:0] B_CNT = (CW + 1)'(BURST_SAMPLES);

    phcal_pkg::cfg_t                cfg;
    phcal_pkg::conv_req_t           conv_req;
    phcal_pkg::conv_rsp_t           conv_rsp;

    phcal_pkg::top_state_t          state_reg, state_next;
    logic [phcal_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [SW-1:0]                  neutral_reg, neutral_next;
    logic                           neutral_cap_reg, neutral_cap_next;
    logic [SW-1:0]                  acid_reg, acid_next;
    logic                           acid_cap_reg, acid_cap_next;
    logic                           in_cal_reg, in_cal_next;
    logic                           cap_done_reg, cap_done_next;
    logic                           hold_valid_reg, hold_valid_next;
    phcal_pkg::result_t             hold_reg, hold_next;
    logic                           out_valid_reg, out_valid_next;
    phcal_pkg::result_t             out_reg, out_next;

    logic                           accept;
    logic                           out_load;
    logic                           burst_last;
    logic [phcal_pkg::SUM_W-1:0]    sum_add;
    logic                           hit7;
    logic                           hit4;
    phcal_pkg::result_t             res;
    logic                           waiting;
    logic                           centi_ok;
    logic                           derr_ok;

    phcal_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    phcal_conv #(.BURST_SAMPLES(BURST_SAMPLES)) u_conv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (conv_req),
        .rsp   (conv_rsp)
    );

    assign out_load    = hold_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = (state_reg == phcal_pkg::ST_IDLE) && (!hold_valid_reg || out_load);
    assign accept      = in_ch.valid && in_ch.ready;
    assign sum_add     = sum_reg + {{(phcal_pkg::SUM_W-SW){1'b0}}, in_ch.sample};
    assign burst_last  = ({1'b0, count_reg} + 1'b1) >= B_CNT;
    assign hit7        = (in_ch.sample > cfg.window7_low) && (in_ch.sample < cfg.window7_high);
    assign hit4        = (in_ch.sample > cfg.window4_low) && (in_ch.sample < cfg.window4_high);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.ph_valid     = out_reg.ph_valid;
    assign out_ch.ph_centi     = out_reg.ph_centi;
    assign out_ch.divide_error = out_reg.divide_error;
    assign out_ch.cal_status   = out_reg.cal_status;
    assign out_ch.progress     = out_reg.progress;

    assign conv_req.start   = accept && (in_ch.command == phcal_pkg::CMD_MEASURE) && burst_last;
    assign conv_req.sum     = sum_add;
    assign conv_req.neutral = neutral_cap_reg ? neutral_reg : cfg.neutral_default;
    assign conv_req.acid    = acid_cap_reg ? acid_reg : cfg.acid_default;

    assign waiting  = (state_reg == phcal_pkg::ST_WAIT);
    assign centi_ok = (out_reg.ph_centi <= phcal_pkg::CENTI_MAX);
    assign derr_ok  = !out_reg.divide_error || (out_reg.ph_valid && (out_reg.ph_centi == '0));

    always_comb
    begin
        state_next       = state_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        neutral_next     = neutral_reg;
        neutral_cap_next = neutral_cap_reg;
        acid_next        = acid_reg;
        acid_cap_next    = acid_cap_reg;
        in_cal_next      = in_cal_reg;
        cap_done_next    = cap_done_reg;
        hold_valid_next  = hold_valid_reg;
        hold_next        = hold_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;

        res.ph_valid     = 1'b0;
        res.ph_centi     = '0;
        res.divide_error = 1'b0;
        res.cal_status   = phcal_pkg::CAL_NONE;
        res.progress     = phcal_pkg::PROG_NONE;

        // output register drains first, holding register refills after
        if (out_valid_reg && out_ch.ready) out_valid_next = 1'b0;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_next        = hold_reg;
            hold_valid_next = 1'b0;
        end

        unique case (state_reg)
            phcal_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    hold_valid_next = 1'b1;
                    unique case (in_ch.command)
                        phcal_pkg::CMD_MEASURE:
                        begin
                            if (burst_last)
                            begin
                                sum_next        = '0;
                                count_next      = '0;
                                hold_valid_next = 1'b0;
                                state_next      = phcal_pkg::ST_WAIT;
                            end
                            else
                            begin
                                sum_next   = sum_add;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        phcal_pkg::CMD_ENTER:
                        begin
                            in_cal_next    = 1'b1;
                            cap_done_next  = 1'b0;
                            res.cal_status = phcal_pkg::CAL_ENTERED;
                            res.progress   = phcal_pkg::PROG_ENTER;
                        end
                        phcal_pkg::CMD_CAPTURE:
                        begin
                            if (in_cal_reg)
                            begin
                                if (hit7)
                                begin
                                    neutral_next     = in_ch.sample;
                                    neutral_cap_next = 1'b1;
                                    cap_done_next    = 1'b1;
                                    res.cal_status   = phcal_pkg::CAL_GOT7;
                                    res.progress     = phcal_pkg::PROG_CAPTURE;
                                end
                                else if (hit4)
                                begin
                                    acid_next      = in_ch.sample;
                                    acid_cap_next  = 1'b1;
                                    cap_done_next  = 1'b1;
                                    res.cal_status = phcal_pkg::CAL_GOT4;
                                    res.progress   = phcal_pkg::PROG_CAPTURE;
                                end
                                else
                                begin
                                    cap_done_next  = 1'b0;
                                    res.cal_status = phcal_pkg::CAL_RETRY;
                                end
                            end
                        end
                        phcal_pkg::CMD_EXIT:
                        begin
                            if (in_cal_reg)
                            begin
                                if (cap_done_reg)
                                begin
                                    res.cal_status = phcal_pkg::CAL_SUCCESS;
                                    res.progress   = phcal_pkg::PROG_DONE;
                                end
                                else
                                begin
                                    res.cal_status = phcal_pkg::CAL_FAILED;
                                end
                                cap_done_next = 1'b0;
                                in_cal_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                            res.cal_status = phcal_pkg::CAL_NONE;
                        end
                    endcase
                    hold_next = res;
                end
            end
            phcal_pkg::ST_WAIT:
            begin
                if (conv_rsp.done)
                begin
                    res.ph_valid     = 1'b1;
                    res.ph_centi     = conv_rsp.centi;
                    res.divide_error = conv_rsp.derr;
                    hold_next        = res;
                    hold_valid_next  = 1'b1;
                    state_next       = phcal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = phcal_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= phcal_pkg::ST_IDLE;
            sum_reg         <= '0;
            count_reg       <= '0;
            neutral_cap_reg <= 1'b0;
            acid_cap_reg    <= 1'b0;
            in_cal_reg      <= 1'b0;
            cap_done_reg    <= 1'b0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            neutral_cap_reg <= neutral_cap_next;
            acid_cap_reg    <= acid_cap_next;
            in_cal_reg      <= in_cal_next;
            cap_done_reg    <= cap_done_next;
            hold_valid_reg  <= hold_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neutral_reg <= neutral_next;
        acid_reg    <= acid_next;
        hold_reg    <= hold_next;
        out_reg     <= out_next;
    end

    `PHCAL_ASSERT_NOW(a_done_only_waiting, conv_rsp.done, waiting, "stray conversion done")
    `PHCAL_ASSERT_NOW(a_centi_range, out_valid_reg, centi_ok, "ph_centi above full range")
    `PHCAL_ASSERT_NOW(a_derr_form, out_valid_reg, derr_ok, "divide error without a zero ph beat")
    `PHCAL_ASSERT_NEXT(a_burst_starts, conv_req.start, waiting, "no conversion at burst end")

endmodule
